@@ rtl/spm_pkg.sv @@
package spm_pkg;

  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_MERGE  = 2'd2;

  localparam int COEFF_W = 16;
  localparam int EXP_W   = 10;
  localparam int RES_W   = 17;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic merge_init;
    logic merge_step;
    logic merge_finish;
  } spm_cmd_t;

  typedef struct packed {
    logic done;
  } spm_sts_t;

endpackage

@@ rtl/sparse_poly_add_sub_merge.sv @@
// Sparse polynomial add/subtract merge. A start with kind 0 or 1 loads one term into the
// first or second store (busy stays low); a full store drops the term and sets overflow.
// A start with kind 2 raises busy for the merge steps (one head comparison each, so
// max(n1, n2) to n1 + n2 steps) and then a closing step; the merge
// loop reads one term of each store per cycle. Results leave as one-cycle out_valid
// strobes, each held back until the next term is produced since the last term is only
// known at the end; the final strobe, with out_last_term, comes in the first cycle with
// busy low. The receiver cannot stall. cfg_we/cfg_wdata set subtract mode and must be
// written idle.
module sparse_poly_add_sub_merge #(
  parameter int MAX_TERMS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_term_coeff,
  input  logic [9:0]         in_term_exp,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output logic               out_valid,
  output logic signed [16:0] out_coeff,
  output logic [9:0]         out_exp,
  output logic               out_last_term,
  output logic               out_empty_result,
  output logic               out_overflow
);
  import spm_pkg::*;

  spm_cmd_t cmd;
  spm_sts_t sts;

  spm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  spm_dp #(
    .MAX_TERMS (MAX_TERMS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .term_coeff       (in_term_coeff),
    .term_exp         (in_term_exp),
    .out_valid        (out_valid),
    .out_coeff        (out_coeff),
    .out_exp          (out_exp),
    .out_last_term    (out_last_term),
    .out_empty_result (out_empty_result),
    .out_overflow     (out_overflow)
  );

endmodule

@@ rtl/spm_ctrl.sv @@
module spm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        kind,
  input  spm_pkg::spm_sts_t sts,
  output spm_pkg::spm_cmd_t cmd,
  output logic              busy
);
  import spm_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_MERGE = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_first  = (kind == KIND_FIRST);
          cmd.load_second = (kind == KIND_SECOND);
          if (kind == KIND_MERGE) begin
            cmd.merge_init = 1'b1;
            state_nxt      = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        if (sts.done) begin
          cmd.merge_finish = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.merge_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == S_MERGE);

endmodule

@@ rtl/spm_dp.sv @@
module spm_dp #(
  parameter int MAX_TERMS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spm_pkg::spm_cmd_t          cmd,
  output spm_pkg::spm_sts_t          sts,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic signed [15:0]         term_coeff,
  input  logic [9:0]                 term_exp,
  output logic                       out_valid,
  output logic signed [16:0]         out_coeff,
  output logic [9:0]                 out_exp,
  output logic                       out_last_term,
  output logic                       out_empty_result,
  output logic                       out_overflow
);
  import spm_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  logic signed [COEFF_W-1:0] a_coeff_mem [MAX_TERMS];
  logic [EXP_W-1:0]          a_exp_mem   [MAX_TERMS];
  logic signed [COEFF_W-1:0] b_coeff_mem [MAX_TERMS];
  logic [EXP_W-1:0]          b_exp_mem   [MAX_TERMS];

  logic [CW-1:0] a_cnt_r, b_cnt_r, i_r, j_r;
  logic [CW-1:0] i_nxt, j_nxt;
  logic          drop_r, sub_r;
  logic          pend_v_r;
  logic signed [RES_W-1:0] pend_coeff_r;
  logic [EXP_W-1:0]        pend_exp_r;

  logic signed [COEFF_W-1:0] ca_r, cb_r;
  logic [EXP_W-1:0]          ea_r, eb_r;

  logic                    out_valid_r, out_last_r, out_empty_r, out_ovf_r;
  logic signed [RES_W-1:0] out_coeff_r;
  logic [EXP_W-1:0]        out_exp_r;

  logic                    a_has, b_has, adv_i, adv_j, produce;
  logic signed [COEFF_W-1:0] ca, cb;
  logic [EXP_W-1:0]        ea, eb, re;
  logic signed [RES_W-1:0] ca_x, cb_eff, rc;

  assign a_has = (i_r < a_cnt_r);
  assign b_has = (j_r < b_cnt_r);
  assign ca    = ca_r;
  assign ea    = ea_r;
  assign cb    = cb_r;
  assign eb    = eb_r;
  assign ca_x  = RES_W'(ca);
  assign cb_eff = sub_r ? -RES_W'(cb) : RES_W'(cb);

  assign sts.done = !a_has && !b_has;

  always_comb begin
    rc      = '0;
    re      = '0;
    adv_i   = 1'b0;
    adv_j   = 1'b0;
    produce = 1'b0;
    priority if (a_has && b_has) begin
      if (ea == eb) begin
        rc    = ca_x + cb_eff;
        re    = ea;
        adv_i = 1'b1;
        adv_j = 1'b1;
      end else if (ea > eb) begin
        rc    = ca_x;
        re    = ea;
        adv_i = 1'b1;
      end else begin
        rc    = cb_eff;
        re    = eb;
        adv_j = 1'b1;
      end
      produce = (rc != '0);
    end else if (a_has) begin
      rc      = ca_x;
      re      = ea;
      adv_i   = 1'b1;
      produce = 1'b1;
    end else if (b_has) begin
      rc      = cb_eff;
      re      = eb;
      adv_j   = 1'b1;
      produce = 1'b1;
    end else begin
      produce = 1'b0;
    end
  end

  // head indexes; the next values address the registered head-term reads
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (cmd.merge_init) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (cmd.merge_step) begin
      if (adv_i) begin
        i_nxt = i_r + CW'(1);
      end
      if (adv_j) begin
        j_nxt = j_r + CW'(1);
      end
    end
  end

  // term stores
  always_ff @(posedge clk) begin
    if (cmd.load_first && (a_cnt_r < CW'(MAX_TERMS))) begin
      a_coeff_mem[a_cnt_r[IW-1:0]] <= term_coeff;
      a_exp_mem[a_cnt_r[IW-1:0]]   <= term_exp;
    end
    if (cmd.load_second && (b_cnt_r < CW'(MAX_TERMS))) begin
      b_coeff_mem[b_cnt_r[IW-1:0]] <= term_coeff;
      b_exp_mem[b_cnt_r[IW-1:0]]   <= term_exp;
    end
    ca_r <= a_coeff_mem[i_nxt[IW-1:0]];
    ea_r <= a_exp_mem[i_nxt[IW-1:0]];
    cb_r <= b_coeff_mem[j_nxt[IW-1:0]];
    eb_r <= b_exp_mem[j_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      drop_r      <= 1'b0;
      sub_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.merge_finish || (cmd.merge_step && produce && pend_v_r);
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      if (cfg_we) begin
        sub_r <= cfg_wdata;
      end
      if (cmd.load_first) begin
        if (a_cnt_r < CW'(MAX_TERMS)) begin
          a_cnt_r <= a_cnt_r + CW'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.load_second) begin
        if (b_cnt_r < CW'(MAX_TERMS)) begin
          b_cnt_r <= b_cnt_r + CW'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.merge_init) begin
        pend_v_r <= 1'b0;
      end
      if (cmd.merge_step && produce) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.merge_finish) begin
        pend_v_r    <= 1'b0;
        a_cnt_r     <= '0;
        b_cnt_r     <= '0;
        drop_r      <= 1'b0;
      end
    end
  end

  // pending term and output payload
  always_ff @(posedge clk) begin
    if (cmd.merge_step && produce) begin
      pend_coeff_r <= rc;
      pend_exp_r   <= re;
      out_coeff_r  <= pend_coeff_r;
      out_exp_r    <= pend_exp_r;
      out_last_r   <= 1'b0;
      out_empty_r  <= 1'b0;
      out_ovf_r    <= drop_r;
    end
    if (cmd.merge_finish) begin
      out_coeff_r <= pend_v_r ? pend_coeff_r : '0;
      out_exp_r   <= pend_v_r ? pend_exp_r : '0;
      out_last_r  <= 1'b1;
      out_empty_r <= !pend_v_r;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coeff        = out_coeff_r;
  assign out_exp          = out_exp_r;
  assign out_last_term    = out_last_r;
  assign out_empty_result = out_empty_r;
  assign out_overflow     = out_ovf_r;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import spm_pkg::*;

  localparam int TERMS_CAP = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 370;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [16:0] coeff;
    logic [9:0]         expo;
    logic               last;
    logic               empty;
    logic               ovf;
  } term_res_t;

  class poly_merge_board;
    int          first_c[TERMS_CAP];
    logic [9:0]  first_e[TERMS_CAP];
    int          second_c[TERMS_CAP];
    logic [9:0]  second_e[TERMS_CAP];
    int          n_first;
    int          n_second;
    bit          dropped;
    bit          sub_mode;
    term_res_t   pending[$];
    term_res_t   staged[$];
    int          fails;
    int          checked;
    int          loads;
    int          merges;
    int          empties;
    int          dropped_merges;
    int          sub_merges;

    function new();
      n_first = 0;
      n_second = 0;
      dropped = 0;
      sub_mode = 0;
      fails = 0;
      checked = 0;
      loads = 0;
      merges = 0;
      empties = 0;
      dropped_merges = 0;
      sub_merges = 0;
    endfunction

    function void stage(int c, logic [9:0] e, bit empty);
      term_res_t t;
      t.coeff = 17'(c);
      t.expo = e;
      t.last = 1'b0;
      t.empty = empty;
      t.ovf = dropped;
      staged.push_back(t);
    endfunction

    function void merge_stores();
      int i;
      int j;
      int rc;
      logic [9:0] re;
      term_res_t t;
      i = 0;
      j = 0;
      staged.delete();
      while (i < n_first && j < n_second) begin
        if (first_e[i] == second_e[j]) begin
          rc = sub_mode ? first_c[i] - second_c[j] : first_c[i] + second_c[j];
          re = first_e[i];
          i++;
          j++;
        end else if (first_e[i] > second_e[j]) begin
          rc = first_c[i];
          re = first_e[i];
          i++;
        end else begin
          rc = sub_mode ? -second_c[j] : second_c[j];
          re = second_e[j];
          j++;
        end
        if (rc != 0) stage(rc, re, 1'b0);
      end
      // tails go out as stored, zeros included
      for (; i < n_first; i++) stage(first_c[i], first_e[i], 1'b0);
      for (; j < n_second; j++) stage(sub_mode ? -second_c[j] : second_c[j], second_e[j], 1'b0);
      if (staged.size() == 0) begin
        stage(0, 10'd0, 1'b1);
        empties++;
      end
      if (dropped) dropped_merges++;
      if (sub_mode) sub_merges++;
      for (int k = 0; k < staged.size(); k++) begin
        t = staged[k];
        t.last = (k == staged.size() - 1);
        pending.push_back(t);
      end
      n_first = 0;
      n_second = 0;
      dropped = 0;
      merges++;
    endfunction

    function void note_transfer(logic [1:0] kind, logic signed [15:0] c, logic [9:0] e);
      case (kind)
        KIND_FIRST: begin
          loads++;
          if (n_first < TERMS_CAP) begin
            first_c[n_first] = int'(c);
            first_e[n_first] = e;
            n_first++;
          end else begin
            dropped = 1'b1;
          end
        end
        KIND_SECOND: begin
          loads++;
          if (n_second < TERMS_CAP) begin
            second_c[n_second] = int'(c);
            second_e[n_second] = e;
            n_second++;
          end else begin
            dropped = 1'b1;
          end
        end
        KIND_MERGE: merge_stores();
        default: ;
      endcase
    endfunction

    function void check_term(logic signed [16:0] c, logic [9:0] e, logic l, logic em,
                             logic ov);
      term_res_t t;
      if (pending.size() == 0) begin
        $error("result with nothing expected: out_coeff %0d out_exp %0d", c, e);
        fails++;
        return;
      end
      t = pending.pop_front();
      checked++;
      if (c !== t.coeff) begin
        $error("out_coeff: expected %0d, got %0d", $signed(t.coeff), c);
        fails++;
      end
      if (e !== t.expo) begin
        $error("out_exp: expected %0d, got %0d", t.expo, e);
        fails++;
      end
      if (l !== t.last) begin
        $error("out_last_term: expected %0b, got %0b", t.last, l);
        fails++;
      end
      if (em !== t.empty) begin
        $error("out_empty_result: expected %0b, got %0b", t.empty, em);
        fails++;
      end
      if (ov !== t.ovf) begin
        $error("out_overflow: expected %0b, got %0b", t.ovf, ov);
        fails++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_kind = KIND_FIRST;
  logic signed [15:0] in_term_coeff = '0;
  logic [9:0]         in_term_exp = '0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               out_valid;
  logic signed [16:0] out_coeff;
  logic [9:0]         out_exp;
  logic               out_last_term;
  logic               out_empty_result;
  logic               out_overflow;

  poly_merge_board sb = new();
  int cycles = 0;
  int items = 0;

  sparse_poly_add_sub_merge #(.MAX_TERMS(TERMS_CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_term_coeff(in_term_coeff),
    .in_term_exp(in_term_exp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_coeff(out_coeff),
    .out_exp(out_exp),
    .out_last_term(out_last_term),
    .out_empty_result(out_empty_result),
    .out_overflow(out_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_term(out_coeff, out_exp, out_last_term, out_empty_result, out_overflow);
  end

  // leaves start high so a following transfer can go back to back
  task automatic send(input logic [1:0] k, input logic signed [15:0] c, input logic [9:0] e);
    start <= 1'b1;
    in_kind <= k;
    in_term_coeff <= c;
    in_term_exp <= e;
    do @(posedge clk); while (busy);
    sb.note_transfer(k, c, e);
    if (k != KIND_UNUSED) items++;
  endtask

  task automatic idle_gap(input bit burst);
    int r;
    int len;
    r = $urandom_range(0, 9);
    len = 0;
    if (!burst) begin
      if (r >= 9) len = $urandom_range(15, 50);
      else if (r >= 5) len = $urandom_range(1, 3);
    end
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.sub_mode = m;
  endtask

  function automatic logic signed [15:0] pick_coeff();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 8) - 4);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] cancel_of(logic signed [15:0] c);
    if (sb.sub_mode) return c;
    return -c;
  endfunction

  task automatic run_random_set();
    logic [9:0]         pool[24];
    logic [9:0]         e1[$];
    logic [9:0]         e2[$];
    logic [9:0]         te[$];
    logic signed [15:0] c1[$];
    logic signed [15:0] c2[$];
    logic signed [15:0] tc[$];
    logic signed [15:0] c;
    int                 cur;
    int                 style;
    int                 n;
    int                 r;
    bit                 burst;
    cur = $urandom_range(1023, 200);
    for (int k = 0; k < 24; k++) begin
      pool[k] = 10'(cur);
      cur -= $urandom_range(1, 8);
    end
    burst = ($urandom_range(0, 4) == 0);
    style = $urandom_range(0, 11);
    case (style)
      0: begin
        // everything cancels in the overlap
        n = ($urandom_range(0, 2) == 0) ? TERMS_CAP : $urandom_range(1, 15);
        for (int k = 0; k < n; k++) begin
          c = pick_coeff();
          e1.push_back(pool[k]);
          c1.push_back(c);
          e2.push_back(pool[k]);
          c2.push_back(cancel_of(c));
        end
        if (n == TERMS_CAP) begin
          e2.push_back(pool[16]);
          c2.push_back(pick_coeff());
        end
      end
      1: begin
        n = $urandom_range(TERMS_CAP + 1, 24);
        for (int k = 0; k < n; k++) begin
          e1.push_back(pool[k]);
          c1.push_back(pick_coeff());
        end
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
          e2.push_back(pool[$urandom_range(0, 23)]);
          c2.push_back(pick_coeff());
        end
        if ($urandom_range(0, 1) == 0) begin
          te = e1; e1 = e2; e2 = te;
          tc = c1; c1 = c2; c2 = tc;
        end
      end
      2: begin
        // arbitrary order
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
          e1.push_back($urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 7)));
          c1.push_back(pick_coeff());
        end
        n = $urandom_range(0, 6);
        for (int k = 0; k < n; k++) begin
          e2.push_back($urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 7)));
          c2.push_back(pick_coeff());
        end
      end
      3: ;
      default: begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, 3);
          c = pick_coeff();
          if (r == 0 || r == 2) begin
            e1.push_back(pool[k]);
            c1.push_back(c);
          end
          if (r == 1 || r == 2) begin
            e2.push_back(pool[k]);
            c2.push_back((r == 2 && $urandom_range(0, 3) == 0) ? cancel_of(c) : pick_coeff());
          end
        end
      end
    endcase
    while (e1.size() > 0 || e2.size() > 0) begin
      if (e2.size() == 0 || (e1.size() > 0 && $urandom_range(0, 1) == 0))
        send(KIND_FIRST, c1.pop_front(), e1.pop_front());
      else
        send(KIND_SECOND, c2.pop_front(), e2.pop_front());
      idle_gap(burst);
      if ($urandom_range(0, 24) == 0) begin
        send(KIND_UNUSED, 16'($urandom), 10'($urandom));
        idle_gap(burst);
      end
    end
    send(KIND_MERGE, 16'($urandom), 10'($urandom));
    idle_gap(burst);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty stores, fields of the merge ignored
    send(KIND_MERGE, -16'sd1, 10'd1023);
    send(KIND_UNUSED, 16'h7fff, 10'h3ff);
    idle_gap(1'b0);
    // coefficient and exponent extremes, add mode
    send(KIND_FIRST, 16'sh7fff, 10'd1023);
    send(KIND_FIRST, -16'sh8000, 10'd0);
    send(KIND_SECOND, 16'sh7fff, 10'd1023);
    send(KIND_SECOND, -16'sh8000, 10'd0);
    send(KIND_MERGE, '0, '0);
    // cancelled overlap, then a zero tail term
    send(KIND_FIRST, 16'sd7, 10'd5);
    send(KIND_SECOND, -16'sd7, 10'd5);
    send(KIND_FIRST, 16'sd3, 10'd2);
    send(KIND_SECOND, 16'sd0, 10'd1);
    send(KIND_MERGE, '0, '0);
    write_mode(1'b1);
    send(KIND_FIRST, 16'sd5, 10'd3);
    send(KIND_FIRST, -16'sh8000, 10'd1);
    send(KIND_SECOND, 16'sd5, 10'd3);
    send(KIND_SECOND, 16'sh7fff, 10'd1);
    send(KIND_SECOND, -16'sh8000, 10'd0);
    send(KIND_MERGE, '0, '0);
    // ascending first list
    send(KIND_FIRST, 16'sd1, 10'd2);
    send(KIND_FIRST, 16'sd2, 10'd9);
    send(KIND_SECOND, 16'sd4, 10'd5);
    send(KIND_MERGE, '0, '0);
    write_mode(1'b0);

    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_mode($urandom_range(0, 1));
      else if ($urandom_range(0, 9) == 0) drain();
      run_random_set();
    end
    drain();
    repeat (20) @(posedge clk);

    $display("ran %0d loads and %0d merges (%0d subtracting), %0d result terms checked",
             sb.loads, sb.merges, sb.sub_merges, sb.checked);
    $display("empty merges %0d, merges with dropped loads %0d", sb.empties, sb.dropped_merges);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
